// ===== design/integer_stack_with_search_assert.svh =====
// Assertion macros for the integer stack with search.
// Included by the top level; relies on clk and rst_n being in scope.
`ifndef INTEGER_STACK_WITH_SEARCH_ASSERT_SVH
`define INTEGER_STACK_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ISS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ISS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/iss_pkg.sv =====
// Shared types and constants for the integer stack with search.
// Used by iss_cell and integer_stack_with_search; depends on nothing.
package iss_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 4;
  localparam int ERR_W     = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH   = 4'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 4'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK   = 4'd2;
  localparam logic [REQ_W-1:0] REQ_DUP    = 4'd3;
  localparam logic [REQ_W-1:0] REQ_SWAP   = 4'd4;
  localparam logic [REQ_W-1:0] REQ_ADD    = 4'd5;
  localparam logic [REQ_W-1:0] REQ_SUB    = 4'd6;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 4'd7;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 4'd8;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OVER  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNDER = 2'd2;

  // What a cell loads on the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_UP,
    CELL_FROM_DOWN
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     hit_clr;
  } cell_ctl_t;

endpackage

// ===== design/iss_cell.sv =====
// One stack cell: holds one entry and one bit of the ripple search flag.
// Depends on iss_pkg for the cell control struct and data width.
module iss_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  iss_pkg::cell_ctl_t                 ctl,
  input  logic signed [iss_pkg::DATA_W-1:0]  up_data,
  input  logic signed [iss_pkg::DATA_W-1:0]  down_data,
  input  logic signed [iss_pkg::DATA_W-1:0]  key,
  input  logic                               live,
  input  logic                               hit_in,
  output logic signed [iss_pkg::DATA_W-1:0]  data_out,
  output logic                               hit_out
);

  logic signed [iss_pkg::DATA_W-1:0] data_r;
  logic signed [iss_pkg::DATA_W-1:0] data_nxt;
  logic                              hit_r;
  logic                              hit_nxt;

  always_comb begin
    case (ctl.op)
      iss_pkg::CELL_FROM_UP:   data_nxt = up_data;
      iss_pkg::CELL_FROM_DOWN: data_nxt = down_data;
      default:                 data_nxt = data_r;
    endcase
  end

  // The flag from the cell above is ORed with this cell's own match, so a
  // hit anywhere travels one cell toward the bottom on every edge.
  assign hit_nxt = ctl.hit_clr ? 1'b0 : (hit_in | (live & (data_r == key)));

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign data_out = data_r;
  assign hit_out  = hit_r;

endmodule

// ===== design/integer_stack_with_search.sv =====
// Top level of the integer stack with search: request decode, fill count,
// result register and the chain of iss_cell instances.
// Depends on iss_pkg, iss_cell and integer_stack_with_search_assert.svh.

// A LIFO of DEPTH signed 32-bit words built as a row of shift cells, cell 0
// holding the top. Push, pop, peek, dup, swap, add, subtract and clear load
// their result beat on the clock that accepts them, so with out_ready held
// high a new request is accepted on every clock. During a search no request
// is accepted: the match flag ripples from the top cell to the bottom cell
// one cell per clock, the result beat is loaded on the clock after that, and
// the next request can be taken on the clock after that (later if out_ready
// is low). Each request returns exactly one result beat from an output
// register; a request that would overflow or underflow reports the error
// and leaves the stack unchanged.
module integer_stack_with_search #(
  parameter int DEPTH = iss_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [iss_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [iss_pkg::DATA_W-1:0]  in_operand,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [iss_pkg::DATA_W-1:0]  out_read_value,
  output logic                               out_found,
  output logic                               out_is_empty,
  output logic [iss_pkg::ERR_W-1:0]          out_error_code
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  state_t                            state_r;
  logic [CW-1:0]                     count_r;
  logic [CW-1:0]                     srch_cnt_r;
  logic signed [iss_pkg::DATA_W-1:0] key_r;

  logic                              out_valid_r;
  logic signed [iss_pkg::DATA_W-1:0] out_read_value_r;
  logic                              out_found_r;
  logic                              out_is_empty_r;
  logic [iss_pkg::ERR_W-1:0]         out_error_code_r;

  logic signed [iss_pkg::DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]                  cell_hit;
  logic [DEPTH-1:0]                  live;
  iss_pkg::cell_ctl_t                ctl [DEPTH];

  logic                              slot_free;
  logic                              in_fire;
  logic                              empty;
  logic                              full;
  logic signed [iss_pkg::DATA_W-1:0] top_val;
  logic signed [iss_pkg::DATA_W-1:0] push_data;
  logic signed [iss_pkg::DATA_W-1:0] op_rv;
  logic [iss_pkg::ERR_W-1:0]         op_err;
  logic [CW-1:0]                     count_nxt;
  iss_pkg::cell_op_t                 shift_op;
  iss_pkg::cell_op_t                 c0_op;
  iss_pkg::cell_op_t                 c1_op;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(DEPTH));
  assign top_val   = empty ? '0 : cell_data[0];

  // Request decode. Nothing here takes effect unless the beat is accepted.
  always_comb begin
    op_rv     = top_val;
    op_err    = iss_pkg::ERR_NONE;
    count_nxt = count_r;
    shift_op  = iss_pkg::CELL_HOLD;
    c0_op     = iss_pkg::CELL_HOLD;
    c1_op     = iss_pkg::CELL_HOLD;
    push_data = in_operand;
    case (in_req_type)
      iss_pkg::REQ_PUSH: begin
        if (full) begin
          op_err = iss_pkg::ERR_OVER;
        end else begin
          count_nxt = count_r + CW'(1);
          shift_op  = iss_pkg::CELL_FROM_UP;
          op_rv     = in_operand;
        end
      end
      iss_pkg::REQ_POP: begin
        if (empty) begin
          op_err = iss_pkg::ERR_UNDER;
        end else begin
          count_nxt = count_r - CW'(1);
          shift_op  = iss_pkg::CELL_FROM_DOWN;
          op_rv     = cell_data[0];
        end
      end
      iss_pkg::REQ_PEEK: begin
        if (empty) begin
          op_err = iss_pkg::ERR_UNDER;
        end
      end
      iss_pkg::REQ_DUP: begin
        if (empty) begin
          op_err = iss_pkg::ERR_UNDER;
        end else if (full) begin
          op_err = iss_pkg::ERR_OVER;
        end else begin
          count_nxt = count_r + CW'(1);
          shift_op  = iss_pkg::CELL_FROM_UP;
          push_data = cell_data[0];
          op_rv     = cell_data[0];
        end
      end
      iss_pkg::REQ_SWAP: begin
        if (count_r < CW'(2)) begin
          op_err = iss_pkg::ERR_UNDER;
        end else begin
          c0_op = iss_pkg::CELL_FROM_DOWN;
          c1_op = iss_pkg::CELL_FROM_UP;
          op_rv = cell_data[1];
        end
      end
      iss_pkg::REQ_ADD: begin
        if (empty) begin
          op_err = iss_pkg::ERR_UNDER;
        end else begin
          push_data = cell_data[0] + in_operand;
          c0_op     = iss_pkg::CELL_FROM_UP;
          op_rv     = push_data;
        end
      end
      iss_pkg::REQ_SUB: begin
        if (empty) begin
          op_err = iss_pkg::ERR_UNDER;
        end else begin
          push_data = cell_data[0] - in_operand;
          c0_op     = iss_pkg::CELL_FROM_UP;
          op_rv     = push_data;
        end
      end
      iss_pkg::REQ_CLEAR: begin
        count_nxt = '0;
        op_rv     = '0;
      end
      default: begin
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [iss_pkg::DATA_W-1:0] up_d;
      logic signed [iss_pkg::DATA_W-1:0] down_d;
      logic                              hit_i;

      if (gi == 0) begin : g_top
        assign up_d  = push_data;
        assign hit_i = 1'b0;
      end else begin : g_mid
        assign up_d  = cell_data[gi-1];
        assign hit_i = cell_hit[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_bot
        assign down_d = '0;
      end else begin : g_nbot
        assign down_d = cell_data[gi+1];
      end

      assign live[gi] = (count_r > CW'(gi));

      always_comb begin
        ctl[gi].hit_clr = in_fire && (in_req_type == iss_pkg::REQ_SEARCH);
        if (!in_fire) begin
          ctl[gi].op = iss_pkg::CELL_HOLD;
        end else if (shift_op != iss_pkg::CELL_HOLD) begin
          ctl[gi].op = shift_op;
        end else if (gi == 0) begin
          ctl[gi].op = c0_op;
        end else if (gi == 1) begin
          ctl[gi].op = c1_op;
        end else begin
          ctl[gi].op = iss_pkg::CELL_HOLD;
        end
      end

      iss_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl[gi]),
        .up_data   (up_d),
        .down_data (down_d),
        .key       (key_r),
        .live      (live[gi]),
        .hit_in    (hit_i),
        .data_out  (cell_data[gi]),
        .hit_out   (cell_hit[gi])
      );
    end
  endgenerate

  // After a search beat the hit flags are cleared; once the flag has rippled
  // down, the bottom cell's flag covers every held entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      srch_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            count_r <= count_nxt;
            if (in_req_type == iss_pkg::REQ_SEARCH) begin
              key_r      <= in_operand;
              srch_cnt_r <= '0;
              state_r    <= ST_SEARCH;
            end else begin
              out_valid_r      <= 1'b1;
              out_read_value_r <= op_rv;
              out_found_r      <= 1'b0;
              out_is_empty_r   <= (count_nxt == '0);
              out_error_code_r <= op_err;
            end
          end
        end
        ST_SEARCH: begin
          if (srch_cnt_r != CW'(DEPTH)) begin
            srch_cnt_r <= srch_cnt_r + CW'(1);
          end else if (slot_free) begin
            out_valid_r      <= 1'b1;
            out_read_value_r <= top_val;
            out_found_r      <= cell_hit[DEPTH-1];
            out_is_empty_r   <= empty;
            out_error_code_r <= iss_pkg::ERR_NONE;
            state_r          <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_found      = out_found_r;
  assign out_is_empty   = out_is_empty_r;
  assign out_error_code = out_error_code_r;

`include "integer_stack_with_search_assert.svh"

  `ISS_ASSERT_NOW(a_count_range, 1'b1, count_r <= CW'(DEPTH), "fill count above capacity")
  `ISS_ASSERT_NOW(a_no_accept_in_search, state_r == ST_SEARCH, !in_ready, "accept during search")
  `ISS_ASSERT_NEXT(a_err_keeps_count, in_fire && (op_err != iss_pkg::ERR_NONE), count_r == $past(count_r), "error request changed fill count")
  `ISS_ASSERT_NOW(a_empty_flag, out_valid_r, out_is_empty_r == (count_r == '0), "empty flag disagrees with fill count")

endmodule
